>>> hw/rtl/tmym_pkg.sv
// Package for the turn maneuver yaw monitor: event and status codes, register
// indexes, angle and age constants, and the heading wrap and age helper functions.
// Has no dependencies; every file of the block imports it.
package tmym_pkg;

  localparam int AGE_W  = 16;
  localparam int TICK_W = 16;
  localparam int LIM_W  = (AGE_W > TICK_W) ? AGE_W : TICK_W;
  localparam int DEG_W  = 9;
  localparam int CALC_W = 12;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  localparam logic signed [CALC_W-1:0] DEG_HALF = CALC_W'(180);
  localparam logic signed [CALC_W-1:0] DEG_FULL = CALC_W'(360);
  localparam logic signed [CALC_W-1:0] WRAP_HI2 = DEG_FULL + DEG_HALF;
  localparam logic signed [CALC_W-1:0] WRAP_LO1 = -DEG_HALF;
  localparam logic signed [CALC_W-1:0] WRAP_LO2 = -WRAP_HI2;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_START  = 3'd1,
    MODE_IDLE   = 3'd2,
    MODE_RESULT = 3'd3,
    MODE_FINISH = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_DONE = 2'd2,
    ST_STOP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_RIGHT    = 2'd1,
    DIR_LEFT     = 2'd2,
    DIR_OTHER    = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    CFG_BASE_TURN   = 3'd0,
    CFG_TURN_MIN    = 3'd1,
    CFG_TURN_MAX    = 3'd2,
    CFG_RIGHT_SIGN  = 3'd3,
    CFG_TOLERANCE   = 3'd4,
    CFG_HOLD_TICKS  = 3'd5,
    CFG_PERIOD      = 3'd6,
    CFG_CHECK_EN    = 3'd7
  } cfg_idx_t;

  function automatic logic signed [DEG_W-1:0] wrap_deg(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] r;
    if (v > WRAP_HI2) begin
      r = v - (DEG_FULL + DEG_FULL);
    end else if (v > DEG_HALF) begin
      r = v - DEG_FULL;
    end else if (v < WRAP_LO2) begin
      r = v + (DEG_FULL + DEG_FULL);
    end else if (v < WRAP_LO1) begin
      r = v + DEG_FULL;
    end else begin
      r = v;
    end
    return r[DEG_W-1:0];
  endfunction

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    return (a != AGE_MAX) ? a + AGE_W'(1) : a;
  endfunction

  function automatic logic age_reached(input logic [AGE_W-1:0] a,
                                       input logic [TICK_W-1:0] limit);
    logic [LIM_W-1:0] lim_x;
    logic [LIM_W-1:0] max_x;
    lim_x = LIM_W'(limit);
    max_x = LIM_W'(AGE_MAX);
    if (lim_x > max_x) begin
      lim_x = max_x;
    end
    return LIM_W'(a) >= lim_x;
  endfunction

endpackage

>>> hw/rtl/turn_maneuver_yaw_monitor.sv
// Top level of the turn maneuver yaw monitor: input register, event decode,
// turn and heading arithmetic, state registers and result register.
// Depends on tmym_pkg.
//
// Usage: events enter on the in_ channel, one beat per event (tick, start, set
// idle, set result, finish). Every accepted beat yields exactly one result beat
// on the out_ channel carrying the status and yaw registers after that event.
// A beat is taken at a rising edge where valid is high and stall is low.
// The input beat is registered, then one pass of adds, clamps and compares
// updates the state and loads the result register, which shows the result.
// One beat per cycle is sustained while the receiver does not stall; the
// rate is set by the single registered pass, which finishes each event as it
// moves from the input register to the result register.
// When the receiver stalls, the result holds and the block keeps one more beat
// in its input register, then raises in_stall until the result is taken.
// Configuration registers are written on the cfg_ channel, which is always
// ready; writes belong between events, when no result is outstanding.
// A synchronous reset (rst_n low) empties both registers, clears the maneuver
// state to idle with zero angles, and loads the register defaults.
module turn_maneuver_yaw_monitor
  import tmym_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_mode,
  input  logic [1:0]              in_direction,
  input  logic signed [DEG_W-1:0] in_line_angle,
  input  logic                    in_line_angle_ok,
  input  logic signed [DEG_W-1:0] in_yaw_sample,
  input  logic                    in_yaw_sample_ok,
  input  logic [1:0]              in_new_status,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic                    out_send_strobe,
  output logic                    out_completion_ok,
  output logic signed [DEG_W-1:0] out_target_turn,
  output logic signed [DEG_W-1:0] out_target_yaw,
  output logic signed [DEG_W-1:0] out_yaw_error,
  output logic signed [DEG_W-1:0] out_end_yaw,
  output logic                    out_yaw_valid,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  // Configuration registers.
  logic [7:0]              base_turn_r;
  logic signed [DEG_W-1:0] turn_min_r;
  logic signed [DEG_W-1:0] turn_max_r;
  logic signed [1:0]       right_sign_r;
  logic [7:0]              tolerance_r;
  logic [TICK_W-1:0]       hold_ticks_r;
  logic [TICK_W-1:0]       period_ticks_r;
  logic                    check_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_turn_r    <= 8'd90;
      turn_min_r     <= 9'sd45;
      turn_max_r     <= 9'sd135;
      right_sign_r   <= 2'sd1;
      tolerance_r    <= 8'd10;
      hold_ticks_r   <= TICK_W'(1000);
      period_ticks_r <= TICK_W'(100);
      check_en_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE_TURN:  base_turn_r    <= cfg_data[7:0];
        CFG_TURN_MIN:   turn_min_r     <= cfg_data[DEG_W-1:0];
        CFG_TURN_MAX:   turn_max_r     <= cfg_data[DEG_W-1:0];
        CFG_RIGHT_SIGN: right_sign_r   <= cfg_data[1:0];
        CFG_TOLERANCE:  tolerance_r    <= cfg_data[7:0];
        CFG_HOLD_TICKS: hold_ticks_r   <= cfg_data[TICK_W-1:0];
        CFG_PERIOD:     period_ticks_r <= cfg_data[TICK_W-1:0];
        CFG_CHECK_EN:   check_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register and flow control.
  logic                    s1_valid_r;
  logic [2:0]              s1_mode_r;
  logic [1:0]              s1_dir_r;
  logic signed [DEG_W-1:0] s1_line_r;
  logic                    s1_line_ok_r;
  logic signed [DEG_W-1:0] s1_yaw_r;
  logic                    s1_yaw_ok_r;
  logic [1:0]              s1_new_status_r;
  logic                    out_valid_r;
  logic                    advance;
  logic                    in_take;
  logic                    s1_go;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign s1_go    = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r       <= in_mode;
      s1_dir_r        <= in_direction;
      s1_line_r       <= in_line_angle;
      s1_line_ok_r    <= in_line_angle_ok;
      s1_yaw_r        <= in_yaw_sample;
      s1_yaw_ok_r     <= in_yaw_sample_ok;
      s1_new_status_r <= in_new_status;
    end
  end

  // Maneuver state.
  status_t                 status_r, status_nxt;
  logic [AGE_W-1:0]        result_age_r, result_age_nxt;
  logic [AGE_W-1:0]        send_age_r, send_age_nxt;
  logic signed [DEG_W-1:0] target_turn_r, target_turn_nxt;
  logic signed [DEG_W-1:0] target_yaw_r, target_yaw_nxt;
  logic signed [DEG_W-1:0] end_yaw_r, end_yaw_nxt;
  logic signed [DEG_W-1:0] yaw_error_r, yaw_error_nxt;
  logic                    yaw_valid_r, yaw_valid_nxt;

  // Turn and heading arithmetic.
  dir_t                     dir;
  logic signed [CALC_W-1:0] base_x;
  logic signed [CALC_W-1:0] line_x;
  logic signed [CALC_W-1:0] yaw_x;
  logic signed [CALC_W-1:0] turn_raw;
  logic signed [CALC_W-1:0] min_x;
  logic signed [CALC_W-1:0] max_x;
  logic signed [DEG_W-1:0]  turn_clamped;
  logic signed [DEG_W-1:0]  turn_sel;
  logic signed [CALC_W-1:0] turn_x;
  logic signed [CALC_W-1:0] sign_x;
  logic signed [CALC_W-1:0] turn_delta;
  logic signed [DEG_W-1:0]  target_start;
  logic signed [DEG_W-1:0]  error_start;
  logic signed [DEG_W-1:0]  error_cap;
  logic                     cap_ok;
  logic [DEG_W-1:0]         error_abs;
  logic                     within_tol;
  logic [AGE_W-1:0]         send_age_inc;

  assign dir    = dir_t'(s1_dir_r);
  assign base_x = CALC_W'({1'b0, base_turn_r});
  assign line_x = s1_line_ok_r ? {{(CALC_W-DEG_W){s1_line_r[DEG_W-1]}}, s1_line_r}
                               : '0;
  assign yaw_x  = {{(CALC_W-DEG_W){s1_yaw_r[DEG_W-1]}}, s1_yaw_r};
  assign min_x  = {{(CALC_W-DEG_W){turn_min_r[DEG_W-1]}}, turn_min_r};
  assign max_x  = {{(CALC_W-DEG_W){turn_max_r[DEG_W-1]}}, turn_max_r};

  assign turn_raw = (dir == DIR_RIGHT) ? base_x + line_x : base_x - line_x;

  always_comb begin
    if (turn_raw < min_x) begin
      turn_clamped = turn_min_r;
    end else if (turn_raw > max_x) begin
      turn_clamped = turn_max_r;
    end else begin
      turn_clamped = turn_raw[DEG_W-1:0];
    end
  end

  assign turn_sel = (dir == DIR_STRAIGHT) ? '0 : turn_clamped;
  assign turn_x   = {{(CALC_W-DEG_W){turn_sel[DEG_W-1]}}, turn_sel};

  always_comb begin
    case (dir)
      DIR_RIGHT: sign_x = {{(CALC_W-2){right_sign_r[1]}}, right_sign_r};
      DIR_LEFT:  sign_x = -{{(CALC_W-2){right_sign_r[1]}}, right_sign_r};
      default:   sign_x = '0;
    endcase
  end

  assign turn_delta   = sign_x * turn_x;
  assign target_start = wrap_deg(yaw_x + turn_delta);
  assign error_start  = wrap_deg({{(CALC_W-DEG_W){target_start[DEG_W-1]}}, target_start}
                                 - yaw_x);
  assign error_cap    = wrap_deg({{(CALC_W-DEG_W){target_yaw_r[DEG_W-1]}}, target_yaw_r}
                                 - yaw_x);
  assign cap_ok       = yaw_valid_r && s1_yaw_ok_r;
  assign error_abs    = error_cap[DEG_W-1] ? -error_cap : error_cap;
  assign within_tol   = error_abs <= {1'b0, tolerance_r};
  assign send_age_inc = age_inc(send_age_r);

  logic strobe;
  logic done_ok;

  always_comb begin
    status_nxt      = status_r;
    result_age_nxt  = result_age_r;
    send_age_nxt    = send_age_r;
    target_turn_nxt = target_turn_r;
    target_yaw_nxt  = target_yaw_r;
    end_yaw_nxt     = end_yaw_r;
    yaw_error_nxt   = yaw_error_r;
    yaw_valid_nxt   = yaw_valid_r;
    strobe          = 1'b0;
    done_ok         = 1'b0;
    if (s1_go) begin
      case (mode_t'(s1_mode_r))
        MODE_TICK: begin
          result_age_nxt = age_inc(result_age_r);
          if (status_r == ST_BUSY) begin
            if (cap_ok) begin
              end_yaw_nxt   = s1_yaw_r;
              yaw_error_nxt = error_cap;
            end else begin
              yaw_valid_nxt = 1'b0;
            end
          end
          if ((status_r == ST_DONE || status_r == ST_STOP)
              && age_reached(result_age_nxt, hold_ticks_r)) begin
            status_nxt = ST_IDLE;
          end
          if (age_reached(send_age_inc, period_ticks_r)) begin
            strobe       = 1'b1;
            send_age_nxt = '0;
          end else begin
            send_age_nxt = send_age_inc;
          end
        end
        MODE_START: begin
          status_nxt      = ST_BUSY;
          target_turn_nxt = turn_sel;
          if (s1_yaw_ok_r) begin
            end_yaw_nxt    = s1_yaw_r;
            yaw_valid_nxt  = 1'b1;
            target_yaw_nxt = target_start;
            yaw_error_nxt  = error_start;
          end else begin
            end_yaw_nxt    = '0;
            yaw_valid_nxt  = 1'b0;
            target_yaw_nxt = '0;
            yaw_error_nxt  = '0;
          end
        end
        MODE_IDLE: begin
          status_nxt = ST_IDLE;
        end
        MODE_RESULT: begin
          status_nxt     = status_t'(s1_new_status_r);
          result_age_nxt = '0;
        end
        MODE_FINISH: begin
          if (cap_ok) begin
            end_yaw_nxt   = s1_yaw_r;
            yaw_error_nxt = error_cap;
          end else begin
            yaw_valid_nxt = 1'b0;
          end
          if (!check_en_r) begin
            done_ok = 1'b1;
          end else begin
            done_ok = cap_ok && within_tol;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r      <= ST_IDLE;
      result_age_r  <= '0;
      send_age_r    <= '0;
      target_turn_r <= '0;
      target_yaw_r  <= '0;
      end_yaw_r     <= '0;
      yaw_error_r   <= '0;
      yaw_valid_r   <= 1'b0;
    end else begin
      status_r      <= status_nxt;
      result_age_r  <= result_age_nxt;
      send_age_r    <= send_age_nxt;
      target_turn_r <= target_turn_nxt;
      target_yaw_r  <= target_yaw_nxt;
      end_yaw_r     <= end_yaw_nxt;
      yaw_error_r   <= yaw_error_nxt;
      yaw_valid_r   <= yaw_valid_nxt;
    end
  end

  // Result register.
  logic [1:0]              out_status_r;
  logic                    out_strobe_r;
  logic                    out_done_r;
  logic signed [DEG_W-1:0] out_target_turn_r;
  logic signed [DEG_W-1:0] out_target_yaw_r;
  logic signed [DEG_W-1:0] out_yaw_error_r;
  logic signed [DEG_W-1:0] out_end_yaw_r;
  logic                    out_yaw_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status_r      <= status_nxt;
      out_strobe_r      <= strobe;
      out_done_r        <= done_ok;
      out_target_turn_r <= target_turn_nxt;
      out_target_yaw_r  <= target_yaw_nxt;
      out_yaw_error_r   <= yaw_error_nxt;
      out_end_yaw_r     <= end_yaw_nxt;
      out_yaw_valid_r   <= yaw_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_send_strobe   = out_strobe_r;
  assign out_completion_ok = out_done_r;
  assign out_target_turn   = out_target_turn_r;
  assign out_target_yaw    = out_target_yaw_r;
  assign out_yaw_error     = out_yaw_error_r;
  assign out_end_yaw       = out_end_yaw_r;
  assign out_yaw_valid     = out_yaw_valid_r;

endmodule

>>> hw/rtl/tmym_checker.sv
// Port-level checker for the turn maneuver yaw monitor, bound to the top level.
// Depends on tmym_pkg and turn_maneuver_yaw_monitor.
module tmym_checker
  import tmym_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_send_strobe,
  input logic out_completion_ok,
  input logic [1:0] out_status
);

  // The input side only backs up behind a stalled result beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result beat");

  // A send strobe comes only from a tick and a pass only from a finish.
  a_strobe_or_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_send_strobe && out_completion_ok))
    else $error("result beat carries both a send strobe and a completion pass");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // A stalled result beat stays and keeps its status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("stalled result beat dropped or changed");

endmodule

bind turn_maneuver_yaw_monitor tmym_checker u_tmym_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_send_strobe   (out_send_strobe),
  .out_completion_ok (out_completion_ok),
  .out_status        (out_status)
);
